FILE: rtl/unordered_table_swap_remove_defines.svh
// assertion macros for the unordered table with swap-remove
// used by files that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef UNORDERED_TABLE_SWAP_REMOVE_DEFINES_SVH
`define UNORDERED_TABLE_SWAP_REMOVE_DEFINES_SVH
`ifndef SYNTHESIS
`define UTSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define UTSR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);
`else
`define UTSR_ASSERT(lbl, prop, msg)
`define UTSR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/utsr_pkg.sv
// shared types and constants of the unordered table with swap-remove
// no dependencies; imported by the front, queue, back and top modules
package utsr_pkg;

  // stream widths
  localparam int unsigned InDataW  = 40;  // slot_index, entry_value, zero fill
  localparam int unsigned InUserW  = 3;   // op
  localparam int unsigned OutDataW = 24;  // result fields, zero fill

  localparam int unsigned SlotW  = 6;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 7;

  // request operation codes on tuser
  localparam logic [InUserW-1:0] OP_ADD     = 3'd0;
  localparam logic [InUserW-1:0] OP_REM_AT  = 3'd1;
  localparam logic [InUserW-1:0] OP_REM_VAL = 3'd2;
  localparam logic [InUserW-1:0] OP_FIND    = 3'd3;
  localparam logic [InUserW-1:0] OP_CLEAR   = 3'd4;

  // command queue depth
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = 1;
  localparam int unsigned QFillW = 2;

  typedef enum logic [2:0] {
    K_ADD     = 3'd0,
    K_REM_AT  = 3'd1,
    K_REM_VAL = 3'd2,
    K_FIND    = 3'd3,
    K_CLEAR   = 3'd4,
    K_BAD     = 3'd5
  } cmd_kind_e;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [SlotW-1:0]   slot;
    logic [ValueW-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic               is_empty;
    logic               is_full;
    logic [CountW-1:0]  entry_count;
    logic [SlotW-1:0]   match_slot;
    logic               found;
    status_e            status;
  } result_t;

endpackage

FILE: rtl/utsr_front.sv
// front end: takes request items and classifies them into queued commands
// depends on utsr_pkg
module utsr_front
  import utsr_pkg::*;
(
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [InDataW-1:0] data_i,   // slot_index [5:0], entry_value [37:6]
  input  logic [InUserW-1:0] user_i,   // op [2:0]
  input  logic               q_full_i,
  output logic               push_o,
  output cmd_t               cmd_o
);

  cmd_kind_e kind;

  always_comb begin
    case (user_i)
      OP_ADD:     kind = K_ADD;
      OP_REM_AT:  kind = K_REM_AT;
      OP_REM_VAL: kind = K_REM_VAL;
      OP_FIND:    kind = K_FIND;
      OP_CLEAR:   kind = K_CLEAR;
      default:    kind = K_BAD;
    endcase
  end

  assign ready_o     = !q_full_i;
  assign push_o      = valid_i && !q_full_i;
  assign cmd_o.kind  = kind;
  assign cmd_o.slot  = data_i[SlotW-1:0];
  assign cmd_o.value = data_i[SlotW+ValueW-1:SlotW];

endmodule

FILE: rtl/utsr_queue.sv
// short command queue between front and back end
// depends on utsr_pkg
module utsr_queue
  import utsr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t              ent_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QFillW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == QFillW'(QDepth));
  assign valid_o = (fill_q != '0);
  assign cmd_o   = ent_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + QPtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + QPtrW'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + QFillW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - QFillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: rtl/utsr_back.sv
// back end: entry memory, fill count, scan and swap-remove sequencer, result register
// depends on utsr_pkg and unordered_table_swap_remove_defines.svh
`include "unordered_table_swap_remove_defines.svh"
module utsr_back
  import utsr_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_valid_i,
  input  cmd_t    q_cmd_i,
  output logic    pop_o,
  output logic    m_valid_o,
  input  logic    m_ready_i,
  output result_t m_result_o
);

  localparam int unsigned AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW    = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W = (ENTRY_BITS < ValueW) ? ENTRY_BITS : ValueW;
  localparam int unsigned CMP_W = (CW > SlotW) ? CW : SlotW;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_MOVE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   chk_q, chk_d;
  logic [AW-1:0]   tgt_q, tgt_d;
  logic            out_valid_q, out_valid_d;
  result_t         out_q;

  logic [VAL_W-1:0] entry_mem_q [CAPACITY];
  logic [VAL_W-1:0] rdata_q;

  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic [VAL_W-1:0] wr_data;

  logic             out_free, res_load, res_found, hit, at_last;
  status_e          res_status;
  logic [SlotW-1:0] res_slot;
  logic [AW-1:0]    last_idx;
  logic [CMP_W-1:0] slot_w, cnt_w;
  result_t          res;

  assign out_free = !out_valid_q || m_ready_i;
  assign last_idx = AW'(count_q - CW'(1));
  assign slot_w   = CMP_W'(q_cmd_i.slot);
  assign cnt_w    = CMP_W'(count_q);
  assign hit      = (rdata_q == VAL_W'(cmd_q.value));
  assign at_last  = (CW'(chk_q) == count_q - CW'(1));

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    count_d    = count_q;
    chk_d      = chk_q;
    tgt_d      = tgt_q;
    pop_o      = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = VAL_W'(q_cmd_i.value);
    res_load   = 1'b0;
    res_status = ST_MISS;
    res_found  = 1'b0;
    res_slot   = '0;

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          pop_o = 1'b1;
          cmd_d = q_cmd_i;
          case (q_cmd_i.kind)
            K_ADD: begin
              res_load = 1'b1;
              if (count_q == CAP_C) begin
                res_status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = AW'(count_q);
                count_d    = count_q + CW'(1);
                res_status = ST_DONE;
              end
            end
            K_REM_AT: begin
              if (slot_w >= cnt_w) begin
                res_load = 1'b1;
              end else if (slot_w == cnt_w - CMP_W'(1)) begin
                // removing the last entry needs no move
                res_load   = 1'b1;
                count_d    = count_q - CW'(1);
                res_status = ST_DONE;
              end else begin
                rd_en   = 1'b1;
                rd_addr = last_idx;
                tgt_d   = AW'(q_cmd_i.slot);
                state_d = S_MOVE;
              end
            end
            K_REM_VAL, K_FIND: begin
              if (count_q == '0) begin
                res_load = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                chk_d   = '0;
                state_d = S_SCAN;
              end
            end
            K_CLEAR: begin
              res_load   = 1'b1;
              count_d    = '0;
              res_status = ST_DONE;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // rdata_q holds the entry at chk_q
        if (hit) begin
          if (cmd_q.kind == K_REM_VAL && !at_last) begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
            tgt_d   = chk_q;
            state_d = S_MOVE;
          end else begin
            res_load   = 1'b1;
            res_status = ST_DONE;
            res_found  = 1'b1;
            res_slot   = SlotW'(chk_q);
            if (cmd_q.kind == K_REM_VAL) begin
              count_d = count_q - CW'(1);
            end
            state_d = S_IDLE;
          end
        end else if (at_last) begin
          res_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = chk_q + AW'(1);
          chk_d   = chk_q + AW'(1);
        end
      end

      S_MOVE: begin
        // rdata_q holds the last entry, copy it into the hole
        wr_en      = 1'b1;
        wr_addr    = tgt_q;
        wr_data    = rdata_q;
        count_d    = count_q - CW'(1);
        res_load   = 1'b1;
        res_status = ST_DONE;
        if (cmd_q.kind == K_REM_VAL) begin
          res_found = 1'b1;
          res_slot  = SlotW'(tgt_q);
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    res.status      = res_status;
    res.found       = res_found;
    res.match_slot  = res_slot;
    res.entry_count = CountW'(count_d);
    res.is_full     = (count_d == CAP_C);
    res.is_empty    = (count_d == '0);

    if (res_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    chk_q <= chk_d;
    tgt_q <= tgt_d;
    if (res_load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= entry_mem_q[rd_addr];
    end
  end

  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

  `UTSR_ASSERT(a_count_bound, count_q <= CAP_C, "fill count above capacity")
  `UTSR_ASSERT(a_scan_range, (state_q != S_SCAN) || (CW'(chk_q) < count_q), "scan past count")
  `UTSR_ASSERT(a_move_target, (state_q != S_MOVE) || (CW'(tgt_q) + CW'(1) < count_q), "move target is last")
  `UTSR_ASSERT(a_result_free, !res_load || !out_valid_q || m_ready_i, "result overwrites pending item")
  `UTSR_ASSERT_NEXT(a_scan_start, pop_o && (q_cmd_i.kind == K_FIND || q_cmd_i.kind == K_REM_VAL) && (count_q != '0), state_q == S_SCAN, "search did not start a scan")

endmodule

FILE: rtl/unordered_table_swap_remove.sv
// sequencing: add, clear, unknown ops, a remove-at that needs no move and a search of an empty
// table register their result at accept; remove-at of another slot reads the last entry, then
// copies it in S_MOVE; find and remove-by-value scan from slot 0 in S_SCAN, and a remove-by-value
// hit before the last slot copies the last entry in S_MOVE; no command is popped outside S_IDLE
// throughput: the back end scans one slot per cycle through the single memory read port
// reset: fill count and handshake state clear at once; entry memory is not cleared
module unordered_table_swap_remove
  import utsr_pkg::*;
#(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned ENTRY_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // slot_index [5:0], entry_value [37:6]
  input  logic [InUserW-1:0]  s_axis_tuser,   // op [2:0]
  // result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata    // status [1:0], found [2], match_slot [8:3],
                                              // entry_count [15:9], is_full [16],
                                              // is_empty [17]
);

  // front to queue
  logic    push;
  cmd_t    push_cmd;
  logic    q_full;

  // queue to back
  logic    q_valid;
  cmd_t    q_cmd;
  logic    pop;

  result_t result;

  // front classifies the op and pushes into the queue whenever there is room
  utsr_front u_front (
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .data_i   (s_axis_tdata),
    .user_i   (s_axis_tuser),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  // two commands of slack so the front keeps taking items while the back is busy
  utsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // back end owns the table and the registered result
  utsr_back #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .pop_o      (pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_result_o (result)
  );

  // result struct is packed lowest field first; pad to whole bytes
  assign m_axis_tdata = {(OutDataW - $bits(result_t))'(0), result};

endmodule
